>>> rtl/ple_pkg.sv
package ple_pkg;

    localparam int OP_WIDTH     = 3;
    localparam int POS_W        = 7;
    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_W      = 7;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_ERASE  = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell; already qualified by accept
    // and by the range and full checks.
    typedef struct packed {
        logic put;         // load the new word at the addressed cell
        logic shift_up;    // cells above the position take the left neighbor
        logic shift_down;  // cells at and above the position take the right neighbor
        logic fetch;       // addressed cell presents its word for a read
    } t_cell_cmd;

endpackage

>>> rtl/ple_cell.sv
module ple_cell
    import ple_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int POS_WIDTH  = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_cell_cmd             i_cmd,
    input  logic [POS_WIDTH-1:0]  i_pos,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rd
);

    localparam logic [POS_WIDTH-1:0] MyIdx = POS_WIDTH'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [DATA_WIDTH-1:0] n_rd;
    logic                  at_pos;
    logic                  above_pos;

    assign at_pos    = (MyIdx == i_pos);
    assign above_pos = (MyIdx > i_pos);

    always_comb begin
        n_data = r_data;
        if (i_cmd.put && at_pos) begin
            n_data = i_value;
        end else if (i_cmd.shift_up && above_pos) begin
            n_data = i_left;
        end else if (i_cmd.shift_down && (above_pos || at_pos)) begin
            n_data = i_right;
        end
        n_rd = (i_cmd.fetch && at_pos) ? r_data : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_rd   <= n_rd;
        end
    end

    assign o_data = r_data;
    assign o_rd   = r_rd;

endmodule

>>> rtl/positional_list_engine_unit.sv
// Positional list engine: an ordered list of signed words held in a row of
// CAPACITY cells plus an element count.
// Request channel: i_valid / o_stall carries operation, position and value
// (append, insert, erase, read, write, clear). Result channel: o_valid /
// i_stall carries status, read value and the element count after the request.
// Each cell holds one entry; an insert or erase moves every cell above the
// position by one place in the same cycle, so a request is taken every clock
// unless a held result stalls the pipe. On acceptance the cells update and the
// addressed cell latches its word; the output register then takes the OR of the
// cell read words and raises o_valid.
// Throughput is one request per cycle while the receiver takes results.
// While a result waits on o_valid with i_stall high, the whole two-stage pipe
// freezes and o_stall follows i_stall; the held result stays unchanged.
// Synchronous reset empties the list (count zero) and drops any work in
// flight; the cell contents are left as they are and read only after written.
module positional_list_engine_unit
    import ple_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OP_WIDTH-1:0]     i_operation,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [STATUS_WIDTH-1:0] o_status,
    output logic signed [VALUE_WIDTH-1:0] o_read_value,
    output logic [COUNT_W-1:0]      o_element_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic                  adv;
    logic                  accept;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_a_valid;
    logic [STATUS_WIDTH-1:0] r_a_status;
    logic [CW-1:0]         r_a_count;
    logic                  r_o_valid;
    logic [STATUS_WIDTH-1:0] r_o_status;
    logic [VALUE_WIDTH-1:0] r_o_rd;
    logic [COUNT_W-1:0]    r_o_count;

    t_status               status;
    t_cell_cmd             cmd;
    t_cell_cmd             cmd_q;
    logic [PW-1:0]         pos_x;
    logic [PW-1:0]         count_x;
    logic [PW-1:0]         cell_pos;
    logic                  full;
    logic [DATA_WIDTH-1:0] word_in;
    logic [DATA_WIDTH-1:0] rd_or;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

    assign adv     = !r_o_valid || !i_stall;
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    assign pos_x   = PW'(i_position);
    assign count_x = PW'(r_count);
    assign full    = (r_count == CW'(CAPACITY));
    assign word_in = DATA_WIDTH'($unsigned(i_value));

    always_comb begin
        status   = ST_OK;
        cmd      = '0;
        n_count  = r_count;
        cell_pos = pos_x;
        unique case (i_operation)
            OP_APPEND: begin
                cell_pos = count_x;
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.put = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_INSERT: begin
                if (pos_x > count_x) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.put      = 1'b1;
                    cmd.shift_up = 1'b1;
                    n_count      = r_count + CW'(1);
                end
            end
            OP_ERASE: begin
                if (pos_x >= count_x) begin
                    status = ST_RANGE;
                end else begin
                    cmd.shift_down = 1'b1;
                    n_count        = r_count - CW'(1);
                end
            end
            OP_READ: begin
                if (pos_x >= count_x) begin
                    status = ST_RANGE;
                end else begin
                    cmd.fetch = 1'b1;
                end
            end
            OP_WRITE: begin
                if (pos_x >= count_x) begin
                    status = ST_RANGE;
                end else begin
                    cmd.put = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Drop the command unless the request is really taken this cycle.
    assign cmd_q = accept ? cmd : '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_left
            assign left = cell_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_right
            assign right = cell_data[k+1];
        end

        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS_WIDTH  (PW),
            .INDEX      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_cmd   (cmd_q),
            .i_pos   (cell_pos),
            .i_value (word_in),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[k]),
            .o_rd    (cell_rd[k])
        );
    end

    // Only the addressed cell of a good read presents its word; all others present zero.
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (adv) begin
                r_a_valid <= accept;
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_status <= status;
            r_a_count  <= n_count;
            r_o_status <= r_a_status;
            r_o_count  <= COUNT_W'(r_a_count);
            r_o_rd     <= VALUE_WIDTH'($signed(rd_or));
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_read_value    = r_o_rd;
    assign o_element_count = r_o_count;

endmodule

>>> verif/list_result_checker.sv
module list_result_checker
    import ple_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic [OP_WIDTH-1:0]           i_operation,
    input  logic [POS_W-1:0]              i_position,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_stall,
    input  logic [STATUS_WIDTH-1:0]       i_status,
    input  logic signed [VALUE_WIDTH-1:0] i_read_value,
    input  logic [COUNT_W-1:0]            i_element_count,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 64;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]       status;
        logic signed [VALUE_WIDTH-1:0] read_value;
        logic [COUNT_W-1:0]            element_count;
    } t_list_result;

    logic signed [VALUE_WIDTH-1:0] list_words [CAPACITY];
    int                            list_len;
    t_list_result                  expected_results [$];
    int                            mismatch_total;

    initial begin
        list_len       = 0;
        mismatch_total = 0;
        o_mismatches   = 0;
        o_outstanding  = 0;
    end

    // Apply one request to the mirrored list and return the word it should produce.
    function automatic t_list_result model_list_request(
        input logic [OP_WIDTH-1:0]           op,
        input logic [POS_W-1:0]              pos,
        input logic signed [VALUE_WIDTH-1:0] val
    );
        t_list_result res;
        int           p;
        p              = int'(pos);
        res.status     = ST_OK;
        res.read_value = '0;
        case (op)
            OP_APPEND: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT: begin
                // range check wins over the full check
                if (p > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = val;
                    list_len++;
                end
            end
            OP_ERASE: begin
                if (p >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            OP_READ: begin
                if (p >= list_len)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_words[p];
            end
            OP_WRITE: begin
                if (p >= list_len)
                    res.status = ST_RANGE;
                else
                    list_words[p] = val;
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.element_count = COUNT_W'(list_len);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            if (i_req_valid && !i_req_stall)
                expected_results.push_back(model_list_request(i_operation, i_position, i_value));
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no request pending: status %0d count %0d",
                           i_status, i_element_count);
                    mismatch_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        mismatch_total++;
                    end
                    if (i_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, i_read_value);
                        mismatch_total++;
                    end
                    if (i_element_count !== want.element_count) begin
                        $error("element_count: expected %0d, actual %0d",
                               want.element_count, i_element_count);
                        mismatch_total++;
                    end
                end
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= expected_results.size();
    end

endmodule

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam logic [OP_WIDTH-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_7 = 3'd7;
    localparam int CAPACITY     = 64;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          req_valid       = 1'b0;
    logic                          req_stall;
    logic [OP_WIDTH-1:0]           req_operation   = OP_APPEND;
    logic [POS_W-1:0]              req_position    = '0;
    logic signed [VALUE_WIDTH-1:0] req_value       = '0;
    logic                          rsp_valid;
    logic                          rsp_stall       = 1'b0;
    logic [STATUS_WIDTH-1:0]       rsp_status;
    logic signed [VALUE_WIDTH-1:0] rsp_read_value;
    logic [COUNT_W-1:0]            rsp_count;

    int mismatches;
    int outstanding;
    int tx_gap_max    = 2;
    int rx_stall_max  = 2;
    bit long_hold_req = 1'b0;
    int list_len_est  = 0;

    always #5 i_clk = ~i_clk;

    positional_list_engine_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_operation     (req_operation),
        .i_position      (req_position),
        .i_value         (req_value),
        .o_valid         (rsp_valid),
        .i_stall         (rsp_stall),
        .o_status        (rsp_status),
        .o_read_value    (rsp_read_value),
        .o_element_count (rsp_count)
    );

    list_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_operation     (req_operation),
        .i_position      (req_position),
        .i_value         (req_value),
        .i_rsp_valid     (rsp_valid),
        .i_rsp_stall     (rsp_stall),
        .i_status        (rsp_status),
        .i_read_value    (rsp_read_value),
        .i_element_count (rsp_count),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // Offer one request word and hold it until taken; keep a rough list length
    // so random positions land mostly in range.
    task automatic send_word(
        input logic [OP_WIDTH-1:0]           op,
        input logic [POS_W-1:0]              pos,
        input logic signed [VALUE_WIDTH-1:0] val
    );
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid     <= 1'b1;
        req_operation <= op;
        req_position  <= pos;
        req_value     <= val;
        do @(posedge i_clk); while (req_stall);
        case (op)
            OP_APPEND: if (list_len_est < CAPACITY) list_len_est++;
            OP_INSERT: if (int'(pos) <= list_len_est && list_len_est < CAPACITY) list_len_est++;
            OP_ERASE:  if (int'(pos) < list_len_est) list_len_est--;
            OP_CLEAR:  list_len_est = 0;
            default: begin
            end
        endcase
    endtask

    // Result side: random stall per word, plus one long hold-off on request.
    initial begin
        int hold;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                hold = $urandom_range(0, rx_stall_max);
                if (hold > 0) begin
                    rsp_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
            end
            rsp_stall <= 1'b0;
            do @(posedge i_clk); while (!rsp_valid);
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int                            ph;
        int                            r;
        logic [OP_WIDTH-1:0]           op;
        logic [POS_W-1:0]              pos;
        logic signed [VALUE_WIDTH-1:0] val;
        int                            gap_by_phase   [NUM_PHASES];
        int                            stall_by_phase [NUM_PHASES];

        gap_by_phase   = '{0, 16, 0, 16, 3, 8, 16, 1};
        stall_by_phase = '{0, 16, 4, 16, 0, 2, 16, 8};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list errors, extreme values, edges of the list
        send_word(OP_CLEAR,  7'd0,   32'sd0);
        send_word(OP_READ,   7'd0,   32'sd0);
        send_word(OP_ERASE,  7'd0,   32'sd0);
        send_word(OP_WRITE,  7'd0,   32'sd5);
        send_word(OP_INSERT, 7'd1,   32'sd9);
        send_word(OP_INSERT, 7'd0,   32'sh8000_0000);
        send_word(OP_APPEND, 7'd0,   32'sh7FFF_FFFF);
        send_word(OP_APPEND, 7'd127, -32'sd1);
        send_word(OP_INSERT, 7'd3,   32'sd0);
        send_word(OP_READ,   7'd0,   32'sd0);
        send_word(OP_READ,   7'd3,   32'sd0);
        send_word(OP_WRITE,  7'd1,   32'sh5555_5555);
        send_word(OP_READ,   7'd1,   32'sd0);
        send_word(OP_ERASE,  7'd0,   32'sd0);
        send_word(OP_ERASE,  7'd2,   32'sd0);
        send_word(OP_READ,   7'd127, 32'sd0);
        send_word(OP_SPARE_6, 7'd0,  32'sh2AAA_AAAA);
        send_word(OP_SPARE_7, 7'd1,  32'sd3);
        send_word(OP_INSERT, 7'd64,  32'sd1);
        send_word(OP_APPEND, 7'd5,   32'sd0);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            tx_gap_max   = gap_by_phase[ph];
            rx_stall_max = stall_by_phase[ph];
            // back up the result side while requests keep coming
            if (ph == 2)
                long_hold_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                case (ph % 4)
                    0: op = (r < 35) ? OP_APPEND : (r < 70) ? OP_INSERT : (r < 80) ? OP_READ :
                            (r < 90) ? OP_WRITE : (r < 96) ? OP_ERASE :
                            (r < 98) ? OP_SPARE_6 : OP_SPARE_7;
                    1: op = (r < 45) ? OP_ERASE : (r < 65) ? OP_READ : (r < 85) ? OP_WRITE :
                            (r < 90) ? OP_APPEND : (r < 95) ? OP_INSERT :
                            (r < 97) ? OP_CLEAR : OP_SPARE_6;
                    2: op = (r < 15) ? OP_APPEND : (r < 35) ? OP_INSERT : (r < 55) ? OP_ERASE :
                            (r < 75) ? OP_READ : (r < 93) ? OP_WRITE :
                            (r < 96) ? OP_CLEAR : OP_SPARE_7;
                    default: op = (r < 30) ? OP_INSERT : (r < 60) ? OP_ERASE :
                                  (r < 75) ? OP_READ : (r < 90) ? OP_WRITE :
                                  (r < 98) ? OP_APPEND : OP_SPARE_6;
                endcase
                if ($urandom_range(0, 99) < 15)
                    pos = POS_W'($urandom_range(0, 127));
                else if (op == OP_INSERT)
                    pos = POS_W'($urandom_range(0, list_len_est));
                else if (list_len_est > 0)
                    pos = POS_W'($urandom_range(0, list_len_est - 1));
                else
                    pos = '0;
                r = $urandom_range(0, 99);
                if (r < 3)
                    val = 32'sh8000_0000;
                else if (r < 6)
                    val = 32'sh7FFF_FFFF;
                else if (r < 8)
                    val = -32'sd1;
                else if (r < 10)
                    val = '0;
                else
                    val = $urandom;
                send_word(op, pos, val);
            end
        end
        req_valid <= 1'b0;

        // let the checker count the last request before watching the backlog
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
